[rtl/core/oahs_pkg.sv]
// ----------------------------------------------------------------------------
// oahs_pkg
// shared types, codes and defaults of the open-addressing hash set unit
// ----------------------------------------------------------------------------
package oahs_pkg;

    // parameter defaults
    localparam int MAX_CAPACITY_DEF   = 1024;
    localparam int START_CAPACITY_DEF = 8;
    localparam int KEY_BYTES_DEF      = 8;

    // fixed field widths
    localparam int LEN_W      = 4;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // configuration reset values
    localparam logic [CFG_DATA_W-1:0] HASH_MULT_RESET  = 32'd71;
    localparam logic [1:0]            LOAD_LIMIT_RESET = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_MULT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_LIMIT = 1'd1;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FAIL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    // slot tags
    typedef enum logic [1:0] {
        TAG_EMPTY = 2'd0,
        TAG_TOMB  = 2'd1,
        TAG_LIVE  = 2'd2
    } tag_t;

    // control sequencer states
    typedef enum logic [3:0] {
        ST_INIT_CLR,
        ST_IDLE,
        ST_HASH,
        ST_GROW_CLR,
        ST_GROW_RD,
        ST_GROW_CHK,
        ST_GROW_HASH,
        ST_GROW_PRD,
        ST_GROW_PCHK,
        ST_GROW_FIN,
        ST_PROBE_SETUP,
        ST_PROBE_RD,
        ST_PROBE_CHK,
        ST_DONE
    } state_t;

endpackage

[rtl/core/open_addressing_hash_set_unit.sv]
// ----------------------------------------------------------------------------
// open_addressing_hash_set_unit
// set of short byte keys in a two-bank open-addressing table with tombstones
// ----------------------------------------------------------------------------
// usage
// - input channel s_*: one transfer carries op (add, delete, query), the key
//   bytes and the key length; one result transfer on m_* follows per item
// - result: status (ok, fail, full), live key count and current capacity
// - cfg_wen/cfg_index/cfg_wdata write the hash multiplier and the load limit;
//   the user must write them only while no item is in flight, the block does not enforce it
// - one item at a time: the key is hashed one byte a cycle, then each probe
//   is a memory read followed by the tag/key check; the next item is taken
//   only once the result has moved into the output register
// - an add over the load limit first doubles the table, unless it is already at
//   MAX_CAPACITY: it clears the doubled range of the other bank, reads every old
//   slot, rehashes and moves each live key, and then switches banks
// - after reset the starting slots in the tag memory of bank 0 are cleared,
//   during which s_ready stays low
// - a result sits in an output register; a stalled receiver holds it there,
//   the next item is still taken but its result waits for the register
// ----------------------------------------------------------------------------
module open_addressing_hash_set_unit #(
    parameter int MAX_CAPACITY   = oahs_pkg::MAX_CAPACITY_DEF,
    parameter int START_CAPACITY = oahs_pkg::START_CAPACITY_DEF,
    parameter int KEY_BYTES      = oahs_pkg::KEY_BYTES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration writes
    input  logic                                cfg_wen,
    input  logic [oahs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [oahs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // input items
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [oahs_pkg::OP_W-1:0]           s_op,
    input  logic [8*KEY_BYTES-1:0]              s_key,
    input  logic [oahs_pkg::LEN_W-1:0]          s_key_length,
    // results
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [oahs_pkg::STATUS_W-1:0]       m_status,
    output logic [$clog2(MAX_CAPACITY):0]       m_key_count,
    output logic [$clog2(MAX_CAPACITY):0]       m_capacity
);

    localparam int ADDR_W     = $clog2(MAX_CAPACITY);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int LOG_W      = $clog2(ADDR_W + 1);
    localparam int KEY_W      = 8 * KEY_BYTES;
    localparam int LEN_W      = oahs_pkg::LEN_W;
    localparam int START_LOG2 = $clog2(START_CAPACITY);
    localparam logic [ADDR_W-1:0] START_MASK = ADDR_W'((1 << START_LOG2) - 1);

    // control and table state
    oahs_pkg::state_t              state_reg, state_next;
    logic [oahs_pkg::OP_W-1:0]     op_reg, op_next;
    logic [KEY_W-1:0]              key_reg, key_next;
    logic [LEN_W-1:0]              len_reg, len_next;
    logic [ADDR_W-1:0]             ihash_reg, ihash_next;
    logic                          bank_reg, bank_next;
    logic [LOG_W-1:0]              log2_reg, log2_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [ADDR_W-1:0]             mult_reg;
    logic [1:0]                    llq_reg;
    logic [ADDR_W-1:0]             y_reg, y_next;
    logic [ADDR_W-1:0]             i_reg, i_next;
    logic [ADDR_W-1:0]             tomb_reg, tomb_next;
    logic                          have_tomb_reg, have_tomb_next;
    logic [ADDR_W-1:0]             idx_reg, idx_next;
    logic [CNT_W-1:0]              gcount_reg, gcount_next;
    logic [KEY_W-1:0]              gkey_reg, gkey_next;
    logic [LEN_W-1:0]              glen_reg, glen_next;
    logic [oahs_pkg::STATUS_W-1:0] status_reg, status_next;

    // output register
    logic                          m_valid_reg, m_valid_next;
    logic [oahs_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    logic [CNT_W-1:0]              m_count_reg, m_count_next;
    logic [CNT_W-1:0]              m_cap_reg, m_cap_next;

    // input conditioning
    logic [LEN_W-1:0]  len_sat;
    logic [KEY_W-1:0]  key_in_mask;
    logic              s_fire;

    // capacity and load
    logic [CNT_W-1:0]  cap_w;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] new_mask;
    logic [CNT_W+1:0]  load_lhs;
    logic [CNT_W+1:0]  load_rhs;
    logic              over_limit;
    logic              can_grow;

    // hash unit
    logic              hash_start;
    logic [KEY_W-1:0]  hash_key;
    logic [LEN_W-1:0]  hash_len;
    logic              hash_done;
    logic [ADDR_W-1:0] hash_val;

    // slot memory
    logic              mem_rd_en;
    logic [ADDR_W:0]   mem_rd_addr;
    logic              mem_tag_wen;
    logic              mem_data_wen;
    logic [ADDR_W:0]   mem_wr_addr;
    oahs_pkg::tag_t    mem_wr_tag;
    logic [KEY_W-1:0]  mem_wr_key;
    logic [LEN_W-1:0]  mem_wr_len;
    oahs_pkg::tag_t    mem_rd_tag;
    logic [KEY_W-1:0]  mem_rd_key;
    logic [LEN_W-1:0]  mem_rd_len;

    // probe check
    logic              hit;
    logic              is_empty;
    logic              is_tomb;
    logic              last_probe;

    assign s_ready = (state_reg == oahs_pkg::ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    // saturate length, drop key bytes above it
    assign len_sat = (s_key_length > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : s_key_length;

    always_comb begin
        for (int b = 0; b < KEY_BYTES; b++) begin
            key_in_mask[8*b +: 8] = (LEN_W'(b) < len_sat) ? s_key[8*b +: 8] : 8'h00;
        end
    end

    assign cap_w    = {{(CNT_W-1){1'b0}}, 1'b1} << log2_reg;
    assign mask     = cap_w[ADDR_W-1:0] - ADDR_W'(1);
    assign new_mask = {mask[ADDR_W-2:0], 1'b1};

    // grow when count * 4 exceeds capacity * quarters
    assign load_lhs   = {count_reg, 2'b00};
    assign load_rhs   = (CNT_W+2)'(cap_w) * (CNT_W+2)'(llq_reg);
    assign over_limit = load_lhs > load_rhs;
    assign can_grow   = log2_reg < LOG_W'(ADDR_W);

    assign hit        = (mem_rd_tag == oahs_pkg::TAG_LIVE) && (mem_rd_len == len_reg) &&
                        (mem_rd_key == key_reg);
    assign is_empty   = (mem_rd_tag == oahs_pkg::TAG_EMPTY);
    assign is_tomb    = (mem_rd_tag == oahs_pkg::TAG_TOMB);
    assign last_probe = (i_reg == mask);

    oahs_hash #(
        .ADDR_W    (ADDR_W),
        .KEY_BYTES (KEY_BYTES)
    ) u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .key_in  (hash_key),
        .len_in  (hash_len),
        .mult    (mult_reg),
        .done    (hash_done),
        .hash    (hash_val)
    );

    oahs_slot_mem #(
        .ADDR_W (ADDR_W),
        .KEY_W  (KEY_W)
    ) u_slot_mem (
        .aclk     (aclk),
        .rd_en    (mem_rd_en),
        .rd_addr  (mem_rd_addr),
        .tag_wen  (mem_tag_wen),
        .data_wen (mem_data_wen),
        .wr_addr  (mem_wr_addr),
        .wr_tag   (mem_wr_tag),
        .wr_key   (mem_wr_key),
        .wr_len   (mem_wr_len),
        .rd_tag   (mem_rd_tag),
        .rd_key   (mem_rd_key),
        .rd_len   (mem_rd_len)
    );

    // sequencer: next state, memory and hash controls
    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        len_next       = len_reg;
        ihash_next     = ihash_reg;
        bank_next      = bank_reg;
        log2_next      = log2_reg;
        count_next     = count_reg;
        y_next         = y_reg;
        i_next         = i_reg;
        tomb_next      = tomb_reg;
        have_tomb_next = have_tomb_reg;
        idx_next       = idx_reg;
        gcount_next    = gcount_reg;
        gkey_next      = gkey_reg;
        glen_next      = glen_reg;
        status_next    = status_reg;
        m_status_next  = m_status_reg;
        m_count_next   = m_count_reg;
        m_cap_next     = m_cap_reg;
        m_valid_next   = m_valid_reg && !m_ready;

        hash_start   = 1'b0;
        hash_key     = mem_rd_key;
        hash_len     = mem_rd_len;
        mem_rd_en    = 1'b0;
        mem_rd_addr  = {bank_reg, y_reg};
        mem_tag_wen  = 1'b0;
        mem_data_wen = 1'b0;
        mem_wr_addr  = {bank_reg, y_reg};
        mem_wr_tag   = oahs_pkg::TAG_EMPTY;
        mem_wr_key   = key_reg;
        mem_wr_len   = len_reg;

        case (state_reg)
            // clear the starting slots of bank 0
            oahs_pkg::ST_INIT_CLR: begin
                mem_tag_wen = 1'b1;
                mem_wr_addr = {1'b0, idx_reg};
                if (idx_reg == START_MASK) begin
                    idx_next   = '0;
                    state_next = oahs_pkg::ST_IDLE;
                end else begin
                    idx_next = idx_reg + ADDR_W'(1);
                end
            end

            oahs_pkg::ST_IDLE: begin
                hash_key = key_in_mask;
                hash_len = len_sat;
                if (s_fire) begin
                    op_next    = s_op;
                    key_next   = key_in_mask;
                    len_next   = len_sat;
                    hash_start = 1'b1;
                    state_next = oahs_pkg::ST_HASH;
                end
            end

            oahs_pkg::ST_HASH: begin
                if (hash_done) begin
                    ihash_next = hash_val;
                    if (op_reg == oahs_pkg::OP_ADD && over_limit && can_grow) begin
                        idx_next   = '0;
                        state_next = oahs_pkg::ST_GROW_CLR;
                    end else if (op_reg == oahs_pkg::OP_ADD || op_reg == oahs_pkg::OP_DELETE ||
                                 op_reg == oahs_pkg::OP_QUERY) begin
                        state_next = oahs_pkg::ST_PROBE_SETUP;
                    end else begin
                        status_next = oahs_pkg::STATUS_FAIL;
                        state_next  = oahs_pkg::ST_DONE;
                    end
                end
            end

            // clear the doubled range of the other bank
            oahs_pkg::ST_GROW_CLR: begin
                mem_tag_wen = 1'b1;
                mem_wr_addr = {~bank_reg, idx_reg};
                if (idx_reg == new_mask) begin
                    idx_next    = '0;
                    gcount_next = '0;
                    state_next  = oahs_pkg::ST_GROW_RD;
                end else begin
                    idx_next = idx_reg + ADDR_W'(1);
                end
            end

            oahs_pkg::ST_GROW_RD: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = {bank_reg, idx_reg};
                state_next  = oahs_pkg::ST_GROW_CHK;
            end

            oahs_pkg::ST_GROW_CHK: begin
                if (mem_rd_tag == oahs_pkg::TAG_LIVE) begin
                    gkey_next  = mem_rd_key;
                    glen_next  = mem_rd_len;
                    hash_start = 1'b1;
                    state_next = oahs_pkg::ST_GROW_HASH;
                end else if (idx_reg == mask) begin
                    state_next = oahs_pkg::ST_GROW_FIN;
                end else begin
                    idx_next   = idx_reg + ADDR_W'(1);
                    state_next = oahs_pkg::ST_GROW_RD;
                end
            end

            oahs_pkg::ST_GROW_HASH: begin
                if (hash_done) begin
                    y_next     = hash_val & new_mask;
                    i_next     = '0;
                    state_next = oahs_pkg::ST_GROW_PRD;
                end
            end

            oahs_pkg::ST_GROW_PRD: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = {~bank_reg, y_reg};
                state_next  = oahs_pkg::ST_GROW_PCHK;
            end

            // first empty slot on the new path takes the key
            oahs_pkg::ST_GROW_PCHK: begin
                if (is_empty) begin
                    mem_tag_wen  = 1'b1;
                    mem_data_wen = 1'b1;
                    mem_wr_addr  = {~bank_reg, y_reg};
                    mem_wr_tag   = oahs_pkg::TAG_LIVE;
                    mem_wr_key   = gkey_reg;
                    mem_wr_len   = glen_reg;
                    gcount_next  = gcount_reg + CNT_W'(1);
                    if (idx_reg == mask) begin
                        state_next = oahs_pkg::ST_GROW_FIN;
                    end else begin
                        idx_next   = idx_reg + ADDR_W'(1);
                        state_next = oahs_pkg::ST_GROW_RD;
                    end
                end else begin
                    y_next     = (y_reg + i_reg + ADDR_W'(1)) & new_mask;
                    i_next     = i_reg + ADDR_W'(1);
                    state_next = oahs_pkg::ST_GROW_PRD;
                end
            end

            oahs_pkg::ST_GROW_FIN: begin
                bank_next  = ~bank_reg;
                log2_next  = log2_reg + LOG_W'(1);
                count_next = gcount_reg;
                state_next = oahs_pkg::ST_PROBE_SETUP;
            end

            oahs_pkg::ST_PROBE_SETUP: begin
                y_next         = ihash_reg & mask;
                i_next         = '0;
                have_tomb_next = 1'b0;
                state_next     = oahs_pkg::ST_PROBE_RD;
            end

            oahs_pkg::ST_PROBE_RD: begin
                mem_rd_en  = 1'b1;
                state_next = oahs_pkg::ST_PROBE_CHK;
            end

            oahs_pkg::ST_PROBE_CHK: begin
                if (hit) begin
                    state_next  = oahs_pkg::ST_DONE;
                    status_next = oahs_pkg::STATUS_OK;
                    if (op_reg == oahs_pkg::OP_ADD) begin
                        status_next = oahs_pkg::STATUS_FAIL;
                    end else if (op_reg == oahs_pkg::OP_DELETE) begin
                        mem_tag_wen = 1'b1;
                        mem_wr_tag  = oahs_pkg::TAG_TOMB;
                        if (count_reg != '0) begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                end else if (is_empty || last_probe) begin
                    state_next  = oahs_pkg::ST_DONE;
                    status_next = oahs_pkg::STATUS_FAIL;
                    if (op_reg == oahs_pkg::OP_ADD) begin
                        // reuse the first tombstone on the path, else this slot
                        if (have_tomb_reg || is_empty || is_tomb) begin
                            mem_tag_wen  = 1'b1;
                            mem_data_wen = 1'b1;
                            mem_wr_tag   = oahs_pkg::TAG_LIVE;
                            if (have_tomb_reg) begin
                                mem_wr_addr = {bank_reg, tomb_reg};
                            end
                            count_next  = count_reg + CNT_W'(1);
                            status_next = oahs_pkg::STATUS_OK;
                        end else begin
                            status_next = oahs_pkg::STATUS_FULL;
                        end
                    end
                end else begin
                    if (is_tomb && !have_tomb_reg) begin
                        have_tomb_next = 1'b1;
                        tomb_next      = y_reg;
                    end
                    y_next     = (y_reg + i_reg + ADDR_W'(1)) & mask;
                    i_next     = i_reg + ADDR_W'(1);
                    state_next = oahs_pkg::ST_PROBE_RD;
                end
            end

            // hand the result over once the output register is free
            oahs_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_count_next  = count_reg;
                    m_cap_next    = cap_w;
                    state_next    = oahs_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = oahs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= oahs_pkg::ST_INIT_CLR;
            bank_reg    <= 1'b0;
            log2_reg    <= LOG_W'(START_LOG2);
            count_reg   <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
            mult_reg    <= oahs_pkg::HASH_MULT_RESET[ADDR_W-1:0];
            llq_reg     <= oahs_pkg::LOAD_LIMIT_RESET;
        end else begin
            state_reg   <= state_next;
            bank_reg    <= bank_next;
            log2_reg    <= log2_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wen) begin
                case (cfg_index)
                    oahs_pkg::CFG_HASH_MULT:  mult_reg <= cfg_wdata[ADDR_W-1:0];
                    oahs_pkg::CFG_LOAD_LIMIT: llq_reg  <= cfg_wdata[1:0];
                    default: begin
                    end
                endcase
            end
        end
        op_reg        <= op_next;
        key_reg       <= key_next;
        len_reg       <= len_next;
        ihash_reg     <= ihash_next;
        y_reg         <= y_next;
        i_reg         <= i_next;
        tomb_reg      <= tomb_next;
        have_tomb_reg <= have_tomb_next;
        gcount_reg    <= gcount_next;
        gkey_reg      <= gkey_next;
        glen_reg      <= glen_next;
        status_reg    <= status_next;
        m_status_reg  <= m_status_next;
        m_count_reg   <= m_count_next;
        m_cap_reg     <= m_cap_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_key_count = m_count_reg;
    assign m_capacity  = m_cap_reg;

endmodule

[rtl/core/oahs_hash.sv]
// ----------------------------------------------------------------------------
// oahs_hash
// byte-serial horner key hash, low address bits only
// ----------------------------------------------------------------------------
module oahs_hash #(
    parameter int ADDR_W    = 10,
    parameter int KEY_BYTES = oahs_pkg::KEY_BYTES_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [8*KEY_BYTES-1:0]     key_in,
    input  logic [oahs_pkg::LEN_W-1:0] len_in,
    input  logic [ADDR_W-1:0]          mult,
    output logic                       done,
    output logic [ADDR_W-1:0]          hash
);

    localparam int KEY_W = 8 * KEY_BYTES;

    logic [ADDR_W-1:0]          h_reg, h_next;
    logic [oahs_pkg::LEN_W-1:0] cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [KEY_W-1:0]           key_reg, key_next;

    logic [oahs_pkg::LEN_W-1:0] cnt_m1;
    logic [oahs_pkg::LEN_W+2:0] shamt;
    logic [KEY_W-1:0]           shifted;
    logic [7:0]                 cur_byte;
    logic [ADDR_W+7:0]          byte_ext;
    logic [2*ADDR_W-1:0]        prod;

    // low bits of h*m+b depend only on low bits of h and m
    assign cnt_m1   = cnt_reg - oahs_pkg::LEN_W'(1);
    assign shamt    = {cnt_m1, 3'b000};
    assign shifted  = key_reg >> shamt;
    assign cur_byte = shifted[7:0];
    assign byte_ext = {{ADDR_W{cur_byte[7]}}, cur_byte};
    assign prod     = {{ADDR_W{1'b0}}, h_reg} * {{ADDR_W{1'b0}}, mult};

    always_comb begin
        h_next    = h_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        key_next  = key_reg;
        if (start) begin
            h_next    = '0;
            cnt_next  = len_in;
            key_next  = key_in;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                h_next   = prod[ADDR_W-1:0] + byte_ext[ADDR_W-1:0];
                cnt_next = cnt_m1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        h_reg   <= h_next;
        key_reg <= key_next;
    end

    assign done = done_reg;
    assign hash = h_reg;

endmodule

[rtl/core/oahs_slot_mem.sv]
// ----------------------------------------------------------------------------
// oahs_slot_mem
// two-bank slot store: tag memory and key/length memory, registered read
// ----------------------------------------------------------------------------
module oahs_slot_mem #(
    parameter int ADDR_W = 10,
    parameter int KEY_W  = 64
) (
    input  logic                       aclk,
    input  logic                       rd_en,
    input  logic [ADDR_W:0]            rd_addr,
    input  logic                       tag_wen,
    input  logic                       data_wen,
    input  logic [ADDR_W:0]            wr_addr,
    input  oahs_pkg::tag_t             wr_tag,
    input  logic [KEY_W-1:0]           wr_key,
    input  logic [oahs_pkg::LEN_W-1:0] wr_len,
    output oahs_pkg::tag_t             rd_tag,
    output logic [KEY_W-1:0]           rd_key,
    output logic [oahs_pkg::LEN_W-1:0] rd_len
);

    localparam int DEPTH  = 2 ** (ADDR_W + 1);
    localparam int DATA_W = KEY_W + oahs_pkg::LEN_W;

    oahs_pkg::tag_t    tag_mem [DEPTH];
    logic [DATA_W-1:0] data_mem [DEPTH];

    oahs_pkg::tag_t    rd_tag_reg;
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (tag_wen) begin
            tag_mem[wr_addr] <= wr_tag;
        end
        if (data_wen) begin
            data_mem[wr_addr] <= {wr_len, wr_key};
        end
        if (rd_en) begin
            rd_tag_reg  <= tag_mem[rd_addr];
            rd_data_reg <= data_mem[rd_addr];
        end
    end

    assign rd_tag = rd_tag_reg;
    assign rd_key = rd_data_reg[KEY_W-1:0];
    assign rd_len = rd_data_reg[DATA_W-1:KEY_W];

endmodule

[sim/open_addressing_hash_set_checker.sv]
// ----------------------------------------------------------------------------
// open_addressing_hash_set_checker
// watches the item and result channels, keeps its own copy of the hash set
// and compares every result transfer with the predicted one
// ----------------------------------------------------------------------------
module open_addressing_hash_set_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [63:0] s_key,
    input  logic [3:0]  s_key_length,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_status,
    input  logic [10:0] m_key_count,
    input  logic [10:0] m_capacity,
    output int          fail_count,
    output int          pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP_MAX = 1024;

    typedef struct packed {
        logic [1:0]  status;
        logic [10:0] key_count;
        logic [10:0] capacity;
    } set_result_t;

    oahs_pkg::tag_t tag_mem [2][CAP_MAX];
    logic [63:0]    key_mem [2][CAP_MAX];
    logic [3:0]     len_mem [2][CAP_MAX];
    bit             bank;
    int             live_keys;
    int             cap_now;
    logic [31:0]    mult;
    logic [1:0]     load_q;
    set_result_t    result_fifo[$];

    assign pending_results = result_fifo.size();

    function automatic logic [63:0] horner_hash(logic [63:0] k, int len);
        logic [63:0] h;
        logic [63:0] b;
        h = 0;
        for (int i = 0; i < len; i++) begin
            b = {{56{k[8*(len-1-i)+7]}}, k[8*(len-1-i) +: 8]};
            h = h * {32'd0, mult} + b;
        end
        return h;
    endfunction

    // returns 0 empty, 1 found, 2 exhausted
    function automatic int walk(logic [63:0] h, logic [63:0] k, int len,
                                output int pos, output bit got_tomb,
                                output int tomb_pos);
        logic [63:0] y;
        int s;
        y = h;
        got_tomb = 0;
        tomb_pos = 0;
        pos = 0;
        for (int i = 0; i < cap_now; i++) begin
            s = int'(y & 64'(cap_now - 1));
            if (tag_mem[bank][s] == oahs_pkg::TAG_EMPTY) begin
                pos = s;
                return 0;
            end
            if (tag_mem[bank][s] == oahs_pkg::TAG_LIVE) begin
                if (len_mem[bank][s] == len && key_mem[bank][s] == k) begin
                    pos = s;
                    return 1;
                end
            end else if (!got_tomb) begin
                got_tomb = 1;
                tomb_pos = s;
            end
            y += 64'(i + 1);
        end
        return 2;
    endfunction

    function automatic void double_table();
        int nb;
        int ncap;
        int cnt;
        int s;
        logic [63:0] y;
        nb = !bank;
        ncap = cap_now * 2;
        cnt = 0;
        for (int i = 0; i < CAP_MAX; i++) tag_mem[nb][i] = oahs_pkg::TAG_EMPTY;
        for (int i = 0; i < cap_now; i++) begin
            if (tag_mem[bank][i] == oahs_pkg::TAG_LIVE) begin
                y = horner_hash(key_mem[bank][i], len_mem[bank][i]);
                for (int j = 0; j < ncap; j++) begin
                    s = int'(y & 64'(ncap - 1));
                    if (tag_mem[nb][s] == oahs_pkg::TAG_EMPTY) begin
                        tag_mem[nb][s] = oahs_pkg::TAG_LIVE;
                        key_mem[nb][s] = key_mem[bank][i];
                        len_mem[nb][s] = len_mem[bank][i];
                        cnt++;
                        break;
                    end
                    y += 64'(j + 1);
                end
            end
        end
        bank = nb;
        cap_now = ncap;
        live_keys = cnt;
    endfunction

    function automatic set_result_t apply_op(logic [1:0] op, logic [63:0] key_in,
                                             logic [3:0] len_in);
        int len;
        logic [63:0] k;
        logic [63:0] h;
        int r;
        int pos;
        int tomb_pos;
        bit got_tomb;
        set_result_t res;
        len = (len_in > 8) ? 8 : len_in;
        k = (len == 8) ? key_in : key_in & ((64'd1 << (8 * len)) - 1);
        h = horner_hash(k, len);
        res.status = oahs_pkg::STATUS_FAIL;
        if (op == oahs_pkg::OP_ADD) begin
            if (live_keys * 4 > cap_now * load_q && cap_now * 2 <= CAP_MAX)
                double_table();
            r = walk(h, k, len, pos, got_tomb, tomb_pos);
            if (r == 1) begin
                res.status = oahs_pkg::STATUS_FAIL;
            end else if (r == 0 || got_tomb) begin
                if (got_tomb) pos = tomb_pos;
                tag_mem[bank][pos] = oahs_pkg::TAG_LIVE;
                key_mem[bank][pos] = k;
                len_mem[bank][pos] = 4'(len);
                live_keys++;
                res.status = oahs_pkg::STATUS_OK;
            end else begin
                res.status = oahs_pkg::STATUS_FULL;
            end
        end else if (op == oahs_pkg::OP_DELETE) begin
            r = walk(h, k, len, pos, got_tomb, tomb_pos);
            if (r == 1) begin
                tag_mem[bank][pos] = oahs_pkg::TAG_TOMB;
                if (live_keys > 0) live_keys--;
                res.status = oahs_pkg::STATUS_OK;
            end
        end else if (op == oahs_pkg::OP_QUERY) begin
            r = walk(h, k, len, pos, got_tomb, tomb_pos);
            res.status = (r == 1) ? oahs_pkg::STATUS_OK : oahs_pkg::STATUS_FAIL;
        end
        res.key_count = 11'(live_keys);
        res.capacity = 11'(cap_now);
        return res;
    endfunction

    always @(posedge aclk) begin
        set_result_t want;
        if (!aresetn) begin
            for (int b = 0; b < 2; b++)
                for (int i = 0; i < CAP_MAX; i++) tag_mem[b][i] = oahs_pkg::TAG_EMPTY;
            bank = 0;
            live_keys = 0;
            cap_now = 8;
            mult = oahs_pkg::HASH_MULT_RESET;
            load_q = oahs_pkg::LOAD_LIMIT_RESET;
            result_fifo.delete();
            fail_count <= 0;
        end else begin
            if (cfg_wen) begin
                if (cfg_index == oahs_pkg::CFG_HASH_MULT) mult = cfg_wdata;
                else load_q = cfg_wdata[1:0];
            end
            if (m_valid && m_ready) begin
                if (result_fifo.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result transfer: status %0d count %0d cap %0d",
                                 m_status, m_key_count, m_capacity);
                end else begin
                    want = result_fifo.pop_front();
                    if (want.status !== m_status || want.key_count !== m_key_count ||
                        want.capacity !== m_capacity) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("result mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                     want.status, want.key_count, want.capacity,
                                     m_status, m_key_count, m_capacity);
                    end
                end
            end
            if (s_valid && s_ready)
                result_fifo.push_back(apply_op(s_op, s_key, s_key_length));
        end
    end
endmodule

[sim/open_addressing_hash_set_unit_tb.sv]
// ----------------------------------------------------------------------------
// open_addressing_hash_set_unit_tb
// drives add/delete/query items into the hash set unit across several
// multiplier and load-limit settings; the checker predicts and compares
// ----------------------------------------------------------------------------
module open_addressing_hash_set_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_wen = 0;
    logic        cfg_index = 0;
    logic [31:0] cfg_wdata = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [1:0]  s_op = 0;
    logic [63:0] s_key = 0;
    logic [3:0]  s_key_length = 1;
    logic        m_valid;
    logic        m_ready = 0;
    logic [1:0]  m_status;
    logic [10:0] m_key_count;
    logic [10:0] m_capacity;
    int          fail_count;
    int          pending_results;

    // receiver modes: random stalls, long hold-off, always ready
    bit          sink_random = 1;
    bit          sink_hold = 0;

    // keys used so far, so adds/deletes/queries hit each other often
    logic [63:0] used_key[$];
    logic [3:0]  used_len[$];

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    open_addressing_hash_set_unit uut (.*);

    open_addressing_hash_set_checker chk (.*);

    // receiver: bursts of stall, a long hold-off on request
    initial begin
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            if (sink_hold) begin
                m_ready <= 0;
                repeat (400) @(posedge aclk);
                sink_hold = 0;
            end else if (sink_random && $urandom_range(3) == 0) begin
                gap = $urandom_range(13, 1);
                m_ready <= 0;
                repeat (gap) @(posedge aclk);
            end else begin
                m_ready <= 1;
                @(posedge aclk);
            end
        end
    end

    task automatic cfg_write(input logic idx, input logic [31:0] val);
        cfg_wen <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wen <= 0;
        @(posedge aclk);
    endtask

    // one item transfer; gap_ok allows a random idle burst in front
    task automatic send_item(input logic [1:0] op, input logic [63:0] k,
                             input logic [3:0] len, input bit gap_ok);
        if (gap_ok && $urandom_range(4) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(13, 1)) @(posedge aclk);
        end
        s_valid <= 1;
        s_op <= op;
        s_key <= k;
        s_key_length <= len;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_random(input bit gap_ok);
        int pick;
        logic [63:0] k;
        logic [3:0] len;
        logic [1:0] op;
        pick = $urandom_range(99);
        // mostly reuse known keys so deletes and duplicate adds hit
        if (used_key.size() > 0 && pick < 55) begin
            pick = $urandom_range(used_key.size() - 1);
            k = used_key[pick];
            len = used_len[pick];
        end else begin
            k = {$urandom, $urandom};
            len = (pick < 95) ? 4'($urandom_range(8, 1)) : 4'($urandom_range(15));
            used_key.push_back(k);
            used_len.push_back(len);
        end
        pick = $urandom_range(99);
        op = (pick < 50) ? oahs_pkg::OP_ADD : (pick < 75) ? oahs_pkg::OP_DELETE :
             (pick < 98) ? oahs_pkg::OP_QUERY : oahs_pkg::OP_UNUSED;
        send_item(op, k, len, gap_ok);
    endtask

    // quiet point for config writes: all results back plus settle time
    task automatic drain();
        s_valid <= 0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: extremes of key and length, every op, odd cases
        send_item(oahs_pkg::OP_ADD, 64'h0, 4'd1, 0);
        send_item(oahs_pkg::OP_ADD, 64'h0, 4'd1, 0);            // duplicate add
        send_item(oahs_pkg::OP_ADD, '1, 4'd8, 0);
        send_item(oahs_pkg::OP_QUERY, '1, 4'd15, 0);            // length saturates
        send_item(oahs_pkg::OP_ADD, 64'hFFFF_FFFF_FFFF_FF80, 4'd1, 0); // high bits ignored
        send_item(oahs_pkg::OP_QUERY, 64'h80, 4'd1, 0);
        send_item(oahs_pkg::OP_ADD, 64'h1234, 4'd0, 0);         // empty key
        send_item(oahs_pkg::OP_QUERY, 64'h0, 4'd0, 0);
        send_item(oahs_pkg::OP_UNUSED, 64'h55, 4'd2, 0);        // unused op code
        send_item(oahs_pkg::OP_DELETE, 64'h0, 4'd1, 0);
        send_item(oahs_pkg::OP_DELETE, 64'h0, 4'd1, 0);         // absent key
        send_item(oahs_pkg::OP_QUERY, 64'h0, 4'd1, 0);
        send_item(oahs_pkg::OP_ADD, 64'h0, 4'd1, 0);            // reuses tombstone
        for (int i = 0; i < 10; i++)
            send_item(oahs_pkg::OP_ADD, 64'(i * 37 + 1), 4'd2, 0); // forces growth
        drain();

        // phases over multiplier and load limit settings, extremes included
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: begin
                    cfg_write(oahs_pkg::CFG_HASH_MULT, 32'd1);
                    cfg_write(oahs_pkg::CFG_LOAD_LIMIT, 32'd1);
                end
                1: begin
                    cfg_write(oahs_pkg::CFG_HASH_MULT, 32'hFFFF_FFFF);
                    cfg_write(oahs_pkg::CFG_LOAD_LIMIT, 32'd3);
                end
                2: begin
                    cfg_write(oahs_pkg::CFG_HASH_MULT, 32'd71);
                    cfg_write(oahs_pkg::CFG_LOAD_LIMIT, 32'd2);
                end
                default: begin
                    cfg_write(oahs_pkg::CFG_HASH_MULT, $urandom);
                    cfg_write(oahs_pkg::CFG_LOAD_LIMIT, 32'($urandom_range(3, 1)));
                end
            endcase
            if (ph == 3) begin
                // long receiver hold-off while items keep coming
                sink_hold = 1;
                for (int i = 0; i < 30; i++) send_random(0);
            end
            if (ph == 6) sink_random = 0;
            for (int i = 0; i < 240; i++) send_random(ph != 6);
            drain();
        end

        s_valid <= 0;
        fork
            begin
                while (pending_results != 0) @(posedge aclk);
                repeat (50) @(posedge aclk);
            end
            begin
                repeat (200000) @(posedge aclk);
            end
        join_any
        if (fail_count == 0 && pending_results == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #40ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule

[filelist.f]
rtl/core/oahs_pkg.sv
rtl/core/oahs_hash.sv
rtl/core/oahs_slot_mem.sv
rtl/core/open_addressing_hash_set_unit.sv
sim/open_addressing_hash_set_checker.sv
sim/open_addressing_hash_set_unit_tb.sv
